// ===== design/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants of the recent color MRU list
// Operation codes, field widths, the result record and the ring slot mapping.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int COLOR_W         = 32;
    localparam int IDX_W           = 4;
    localparam int CNT_W           = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CAP_RESET_VAL   = 16;
    localparam int CNT_MAX         = (1 << CNT_W) - 1;

    typedef enum logic [1:0] {
        FUNC_PUSH,
        FUNC_PUSH_UNIQUE,
        FUNC_READ,
        FUNC_CLEAR
    } func_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               valid;
        logic [CNT_W-1:0]   count;
    } result_t;

    // Physical slot of a logical position: (head - 1 - logical) modulo cap.
    // Callers keep head and logical below cap.
    function automatic logic [CNT_W-1:0] slot_of(logic [CNT_W-1:0] head,
                                                 logic [CNT_W-1:0] cap,
                                                 logic [CNT_W-1:0] logical);
        logic [CNT_W:0] s;
        s = {1'b0, head} + {1'b0, cap} - {{CNT_W{1'b0}}, 1'b1} - {1'b0, logical};
        if (s >= {1'b0, cap}) begin
            s = s - {1'b0, cap};
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

// ===== design/rcm_ram.sv =====
// ----------------------------------------------------------------------------
// rcm_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rcm_core.sv =====
// ----------------------------------------------------------------------------
// rcm_core: sequencer of the recent color MRU list
// Holds capacity, head and count, and accesses the ring store for push, read and push unique.
// ----------------------------------------------------------------------------
module rcm_core #(
    parameter int MAX_ENTRIES = rcm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_func,
    input  logic [rcm_pkg::COLOR_W-1:0]  in_color,
    input  logic [rcm_pkg::IDX_W-1:0]    in_ridx,
    input  logic                         cfg_valid,
    input  logic [rcm_pkg::CNT_W-1:0]    cfg_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output rcm_pkg::result_t             res
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = rcm_pkg::CNT_W;
    localparam logic [CW-1:0] CAP_LIMIT =
        CW'((MAX_ENTRIES > rcm_pkg::CNT_MAX) ? rcm_pkg::CNT_MAX : MAX_ENTRIES);
    localparam logic [CW-1:0] CAP_RESET =
        CW'((MAX_ENTRIES > rcm_pkg::CAP_RESET_VAL) ? rcm_pkg::CAP_RESET_VAL : MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_PUSH,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 cap_reg;
    logic [CW-1:0]                 head_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 idx_reg;
    logic                          found_reg;
    logic [rcm_pkg::COLOR_W-1:0]   color_reg;
    rcm_pkg::result_t              res_reg;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [rcm_pkg::COLOR_W-1:0]   wr_data;
    logic [AW-1:0]                 rd_addr;
    logic [rcm_pkg::COLOR_W-1:0]   rd_data;

    logic [CW-1:0]                 slot_idx;
    logic [CW-1:0]                 slot_prev;
    logic [CW-1:0]                 head_next;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 cap_next;
    logic [CW-1:0]                 ridx_ext;

    function automatic logic [AW-1:0] to_addr(logic [CW-1:0] s);
        logic [AW+CW-1:0] w;
        w = {{AW{1'b0}}, s};
        return w[AW-1:0];
    endfunction

    rcm_ram #(
        .WIDTH (rcm_pkg::COLOR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ring_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_idx  = rcm_pkg::slot_of(head_reg, cap_reg, idx_reg);
    assign slot_prev = rcm_pkg::slot_of(head_reg, cap_reg, idx_reg - CW'(1));
    assign ridx_ext  = {{(CW-rcm_pkg::IDX_W){1'b0}}, in_ridx};

    // Head and count after a push.
    assign head_next  = (head_reg + CW'(1) >= cap_reg) ? '0 : head_reg + CW'(1);
    assign count_next = (count_reg < cap_reg) ? count_reg + CW'(1) : count_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cap_next = CW'(1);
        end else if (cfg_data > CAP_LIMIT) begin
            cap_next = CAP_LIMIT;
        end else begin
            cap_next = cfg_data;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = to_addr(head_reg);
        wr_data = color_reg;
        rd_addr = to_addr(slot_idx);
        if (state_reg == S_SHF_WR) begin
            wr_en   = 1'b1;
            wr_addr = to_addr(slot_prev);
            wr_data = rd_data;
        end else if (state_reg == S_PUSH) begin
            wr_en   = 1'b1;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        color_reg <= in_color;
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        unique case (rcm_pkg::func_t'(in_func))
                            rcm_pkg::FUNC_PUSH: begin
                                state_reg <= S_PUSH;
                            end
                            rcm_pkg::FUNC_PUSH_UNIQUE: begin
                                state_reg <= S_SRCH_RD;
                            end
                            rcm_pkg::FUNC_READ: begin
                                if (ridx_ext < count_reg) begin
                                    idx_reg   <= ridx_ext;
                                    state_reg <= S_RD_ISSUE;
                                end else begin
                                    res_reg   <= '{color: '0, valid: 1'b0, count: count_reg};
                                    state_reg <= S_EMIT;
                                end
                            end
                            rcm_pkg::FUNC_CLEAR: begin
                                count_reg <= '0;
                                res_reg   <= '{color: '0, valid: 1'b0, count: '0};
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_RD_ISSUE: begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    res_reg   <= '{color: rd_data, valid: 1'b1, count: count_reg};
                    state_reg <= S_EMIT;
                end
                S_SRCH_RD: begin
                    if (idx_reg == count_reg) begin
                        state_reg <= S_PUSH;
                    end else begin
                        state_reg <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    idx_reg <= idx_reg + CW'(1);
                    if (rd_data == color_reg) begin
                        found_reg <= 1'b1;
                        state_reg <= S_SHF_RD;
                    end else begin
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SHF_RD: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_PUSH;
                    end else begin
                        state_reg <= S_SHF_WR;
                    end
                end
                S_SHF_WR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SHF_RD;
                end
                S_PUSH: begin
                    head_reg  <= head_next;
                    count_reg <= count_next;
                    res_reg   <= '{color: '0, valid: found_reg, count: count_next};
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // A capacity write empties the list; the user must send it only while idle, the core does not enforce it.
            if (cfg_valid) begin
                cap_reg   <= cap_next;
                head_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

endmodule

// ===== design/recent_color_mru_list.sv =====
// ----------------------------------------------------------------------------
// recent_color_mru_list: most-recently-used list of RGBA colors
// Top level with stream ports, the sequencer and an output register stage.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the s_ channel is one operation, selected by s_tuser: push,
// push unique (move to front), read entry, or clear. Every operation yields
// exactly one beat on the m_ channel carrying the read color (zero unless a
// read hits), a flag in m_tuser and the entry count after the operation.
// The colors live in a ring store with one write and one registered read
// port; the sequencer takes one operation at a time. Push unique searches
// the list and closes the gap through the single read port, one entry at
// a time.
// An output register separates the sides, so a result may wait for the
// receiver while the next operation is accepted; that operation then holds
// its own result until the register frees up.
// cfg_data writes the capacity (0 is taken as 1, values above MAX_ENTRIES
// are clipped) and empties the list; write it only while no beat is pending.
// After reset the list is empty, the capacity is 16 (or MAX_ENTRIES if smaller) and the store contents
// are unknown; entries are only read after being written.
// ----------------------------------------------------------------------------
module recent_color_mru_list #(
    parameter int MAX_ENTRIES = rcm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Operation stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // [31:0] color_in, [35:32] read_index
    input  logic [1:0]                  s_tuser,   // [1:0] func
    // Capacity write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rcm_pkg::CNT_W-1:0]   cfg_data,
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // [31:0] color_out, [36:32] count_out
    output logic [0:0]                  m_tuser    // [0] valid_res
);

    rcm_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;
    logic             m_valid_reg;
    rcm_pkg::result_t m_res_reg;

    rcm_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_color  (s_tdata[31:0]),
        .in_ridx   (s_tdata[35:32]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The configuration register is always ready to take a beat.
    assign cfg_ready = 1'b1;

    // The output register takes a new result whenever it is empty or its
    // current beat is leaving in this cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_res_reg   <= res;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.count, m_res_reg.color};
    assign m_tuser  = m_res_reg.valid;

endmodule
